[rtl/lr_pkg.sv]
// ----------------------------------------------------------------------------
// lr_pkg: shared definitions for the line rasterizer
// Holds the default coordinate width and the request mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

  // Default coordinate width; the top level may override it (4 to 16).
  localparam int unsigned COORD_BITS_DEF = 11;

  // Request mode codes
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_e;

endpackage : lr_pkg

`default_nettype wire

[rtl/lr_if.sv]
// ----------------------------------------------------------------------------
// lr_if: request and pixel channels of the line rasterizer
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: load endpoints or step to the next pixel
interface lr_req_if #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
);
  import lr_pkg::*;

  logic                         valid;
  logic                         ready;
  mode_e                        mode;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface : lr_req_if

// Pixel channel: one pixel per item, last flags the line's final pixel
interface lr_pix_if #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface : lr_pix_if

`default_nettype wire

[rtl/line_rasterizer.sv]
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line rasterizer, all eight octants
// Loads two signed endpoints, then emits one pixel per step request,
// both endpoints included, with the final pixel flagged.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   mode, start_x, start_y, end_x, end_y
//   pix_o    out  valid/ready   pixel_x, pixel_y, last
//
// One request per cycle while req_i.ready is high. A step request updates the
// line state and fills the pixel register in the cycle it is taken; the pixel
// is offered the next cycle. req_i.ready is low only while the pixel register
// is full and pix_o is stalled. A load or a step while idle gives no pixel.
// Reset clears the line state to idle and empties the pixel register.
//
`default_nettype none

module line_rasterizer #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  lr_req_if.sink   req_i,
  lr_pix_if.source pix_o
);
  import lr_pkg::*;

  localparam int unsigned CW = COORD_BITS;      // coordinate width
  localparam int unsigned DW = COORD_BITS + 1;  // delta width
  localparam int unsigned EW = COORD_BITS + 3;  // error term width

  // Line state
  logic signed [CW-1:0] cur_major_q, cur_major_d;
  logic signed [CW-1:0] cur_minor_q, cur_minor_d;
  logic signed [EW-1:0] error_term_q, error_term_d;
  logic        [DW-1:0] major_delta_q, major_delta_d;
  logic        [DW-1:0] minor_delta_q, minor_delta_d;
  logic        [DW-1:0] steps_left_q, steps_left_d;
  logic                 steep_flag_q, steep_flag_d;
  logic                 minor_down_q, minor_down_d;
  logic                 active_q, active_d;

  // Pixel register
  logic                 out_valid_q, out_valid_d;
  logic signed [CW-1:0] out_x_q, out_x_d;
  logic signed [CW-1:0] out_y_q, out_y_d;
  logic                 out_last_q, out_last_d;

  logic req_fire, is_load, is_step, emit;

  // Take a request whenever the pixel register is free or draining
  assign req_i.ready = !out_valid_q || pix_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign is_load     = req_fire && (req_i.mode == MODE_LOAD);
  assign is_step     = req_fire && (req_i.mode == MODE_STEP);
  assign emit        = is_step && active_q;

  // Normalize endpoints of a load request
  logic signed [DW-1:0] dx, dy;
  logic        [DW-1:0] adx, ady;
  logic                 steep;
  logic signed [CW-1:0] ma, na, mb, nb;
  logic                 swap;
  logic signed [CW-1:0] start_minor, end_minor;
  logic        [DW-1:0] ld_major, ld_minor;
  logic signed [EW-1:0] ld_error;

  always_comb begin
    dx = {req_i.end_x[CW-1], req_i.end_x} - {req_i.start_x[CW-1], req_i.start_x};
    dy = {req_i.end_y[CW-1], req_i.end_y} - {req_i.start_y[CW-1], req_i.start_y};
    adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
    steep = ady > adx;
    ma = steep ? req_i.start_y : req_i.start_x;
    na = steep ? req_i.start_x : req_i.start_y;
    mb = steep ? req_i.end_y   : req_i.end_x;
    nb = steep ? req_i.end_x   : req_i.end_y;
    swap = mb < ma;
    start_minor = swap ? nb : na;
    end_minor   = swap ? na : nb;
    // Extent along each axis does not depend on the swap
    ld_major = steep ? ady : adx;
    ld_minor = steep ? adx : ady;
    ld_error = $signed({1'b0, ld_minor, 1'b0}) - $signed({2'b00, ld_major});
  end

  // Advance the line state: load, step, or hold
  logic signed [EW-1:0] two_minor, two_major;

  always_comb begin
    two_minor = $signed({1'b0, minor_delta_q, 1'b0});
    two_major = $signed({1'b0, major_delta_q, 1'b0});

    cur_major_d   = cur_major_q;
    cur_minor_d   = cur_minor_q;
    error_term_d  = error_term_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    steps_left_d  = steps_left_q;
    steep_flag_d  = steep_flag_q;
    minor_down_d  = minor_down_q;
    active_d      = active_q;

    if (is_load) begin
      cur_major_d   = swap ? mb : ma;
      cur_minor_d   = start_minor;
      error_term_d  = ld_error;
      major_delta_d = ld_major;
      minor_delta_d = ld_minor;
      steps_left_d  = ld_major;
      steep_flag_d  = steep;
      minor_down_d  = end_minor < start_minor;
      active_d      = 1'b1;
    end else if (emit) begin
      if (steps_left_q == '0) begin
        active_d = 1'b0;
      end else begin
        if (!error_term_q[EW-1]) begin
          cur_minor_d  = minor_down_q ? cur_minor_q - CW'(1) : cur_minor_q + CW'(1);
          error_term_d = error_term_q + two_minor - two_major;
        end else begin
          error_term_d = error_term_q + two_minor;
        end
        cur_major_d  = cur_major_q + CW'(1);
        steps_left_d = steps_left_q - DW'(1);
      end
    end
  end

  // Fill the pixel register on a step of an active line, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q && !pix_o.ready;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_x_d     = steep_flag_q ? cur_minor_q : cur_major_q;
      out_y_d     = steep_flag_q ? cur_major_q : cur_minor_q;
      out_last_d  = (steps_left_q == '0);
    end
  end

  // Control and line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_major_q   <= '0;
      cur_minor_q   <= '0;
      error_term_q  <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      steps_left_q  <= '0;
      steep_flag_q  <= 1'b0;
      minor_down_q  <= 1'b0;
      active_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      cur_major_q   <= cur_major_d;
      cur_minor_q   <= cur_minor_d;
      error_term_q  <= error_term_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
      steps_left_q  <= steps_left_d;
      steep_flag_q  <= steep_flag_d;
      minor_down_q  <= minor_down_d;
      active_q      <= active_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Pixel payload
  always_ff @(posedge clk_i) begin
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_last_q <= out_last_d;
  end

  assign pix_o.valid   = out_valid_q;
  assign pix_o.pixel_x = out_x_q;
  assign pix_o.pixel_y = out_y_q;
  assign pix_o.last    = out_last_q;

  // Checks
  a_step_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("step on an active line gave no pixel");

  a_last_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && steps_left_q == '0) |=> (!active_q && out_last_q))
    else $error("final pixel did not end the line");

  a_minor_le_major: assert property (@(posedge clk_i) disable iff (!rst_ni)
    minor_delta_q <= major_delta_q)
    else $error("minor extent exceeds major extent");

  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_left_q <= major_delta_q)
    else $error("remaining steps exceed line length");

endmodule : line_rasterizer

`default_nettype wire
